/* hdl/omd_pkg.sv */
// ----------------------------------------------------------------------------
// omd_pkg: shared definitions for the obstacle margin dilation block
// Field widths, register map, reset values and default size limits.
// ----------------------------------------------------------------------------
package omd_pkg;

	localparam int DEF_MAX_WIDTH  = 1024;
	localparam int DEF_MAX_HEIGHT = 1024;
	localparam int DEF_MAX_MARGIN = 8;

	localparam int PIX_W      = 8;
	localparam int CFG_DIM_W  = 11;
	localparam int CFG_MRG_W  = 4;
	localparam int APB_AW     = 4;
	localparam int APB_DW     = 32;

	localparam logic [CFG_DIM_W-1:0] RST_FRAME_WIDTH  = 11'd1024;
	localparam logic [CFG_DIM_W-1:0] RST_FRAME_HEIGHT = 11'd1024;
	localparam logic [CFG_MRG_W-1:0] RST_MARGIN       = 4'd2;
	localparam logic [PIX_W-1:0]     RST_THRESHOLD    = 8'd125;

	localparam logic MODE_PIXEL = 1'b0;
	localparam logic MODE_DRAIN = 1'b1;

	typedef enum logic [1:0] {
		REG_FRAME_WIDTH,
		REG_FRAME_HEIGHT,
		REG_MARGIN,
		REG_THRESHOLD
	} reg_idx_t;

endpackage

/* hdl/omd_if.sv */
// ----------------------------------------------------------------------------
// omd_if: request channels of the obstacle margin dilation block
// Map pixel channel in, dilated pixel channel out, valid/ready handshake.
// ----------------------------------------------------------------------------
interface omd_in_if import omd_pkg::*; ();
	logic             valid;
	logic             ready;
	logic             mode;
	logic [PIX_W-1:0] pixel_in;

	modport source (output valid, output mode, output pixel_in, input ready);
	modport sink   (input valid, input mode, input pixel_in, output ready);
endinterface

interface omd_out_if import omd_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] pixel_out;
	logic             frame_last;

	modport source (output valid, output pixel_out, output frame_last, input ready);
	modport sink   (input valid, input pixel_out, input frame_last, output ready);
endinterface

/* hdl/omd_cell.sv */
// ----------------------------------------------------------------------------
// omd_cell: one window cell of the horizontal dilation chain
// Holds one column flag and pixel, passes them on, reports a window hit.
// ----------------------------------------------------------------------------
module omd_cell import omd_pkg::*; #(
	parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
	parameter int MAX_MARGIN = DEF_MAX_MARGIN,
	localparam int WW  = $clog2(MAX_WIDTH + 1),
	localparam int VW  = $clog2(2 * MAX_MARGIN + 2),
	localparam int SLW = $clog2(2 * MAX_MARGIN + 1),
	localparam int CMW = $clog2(MAX_WIDTH + MAX_MARGIN)
) (
	input  logic             clk,
	input  logic             shift,
	input  logic             vf_in,
	input  logic [PIX_W-1:0] pix_in,
	input  logic [SLW-1:0]   slot,
	input  logic [CMW-1:0]   cm,
	input  logic [WW-1:0]    width,
	input  logic [VW-1:0]    span,
	output logic             vf_out,
	output logic [PIX_W-1:0] pix_out,
	output logic             hit
);
	localparam int LW = CMW + 1;

	logic             vf_q;
	logic [PIX_W-1:0] pix_q;

	always_ff @(posedge clk) begin
		if (shift) begin
			vf_q  <= vf_in;
			pix_q <= pix_in;
		end
	end

	// column of this slot is centre + margin - slot; keep it inside the row
	assign hit = vf_q
		&& (LW'(slot) <= LW'(span))
		&& (LW'(cm) >= LW'(slot))
		&& (LW'(cm) < (LW'(width) + LW'(slot)));

	assign vf_out  = vf_q;
	assign pix_out = pix_q;
endmodule

/* hdl/omd_vert.sv */
// ----------------------------------------------------------------------------
// omd_vert: vertical obstacle distance per column
// Read-modify-write of rows-since-obstacle counters, one column per request.
// ----------------------------------------------------------------------------
module omd_vert import omd_pkg::*; #(
	parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
	parameter int MAX_MARGIN = DEF_MAX_MARGIN,
	localparam int CAW = $clog2(MAX_WIDTH),
	localparam int VW  = $clog2(2 * MAX_MARGIN + 2)
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           adv,
	input  logic           take,
	input  logic [CAW-1:0] col,
	input  logic           first_row,
	input  logic           obst,
	input  logic [VW-1:0]  span,
	output logic           valid_s1,
	output logic           vf_s1
);
	localparam logic [VW-1:0] VMAX = '1;

	logic [VW-1:0]  mem [MAX_WIDTH];
	logic [VW-1:0]  rd_q;
	logic [VW-1:0]  fwd_val_q;
	logic           fwd_q;
	logic [CAW-1:0] col_s1;
	logic           first_s1;
	logic           obst_s1;
	logic [VW-1:0]  span_s1;
	logic [VW-1:0]  v_old;
	logic [VW-1:0]  v_new;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			fwd_q    <= 1'b0;
		end else if (adv) begin
			valid_s1 <= take;
			fwd_q    <= take && valid_s1 && (col == col_s1);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			col_s1    <= col;
			first_s1  <= first_row;
			obst_s1   <= obst;
			span_s1   <= span;
			fwd_val_q <= v_new;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && take) begin
			rd_q <= mem[col];
		end
		if (adv && valid_s1) begin
			mem[col_s1] <= v_new;
		end
	end

	// rows above the frame hold no obstacle; a one-column map bypasses the store
	assign v_old = first_s1 ? VMAX : (fwd_q ? fwd_val_q : rd_q);
	assign v_new = obst_s1 ? '0 : ((v_old == VMAX) ? VMAX : v_old + VW'(1));
	assign vf_s1 = (v_new <= span_s1);
endmodule

/* hdl/omd_pdly.sv */
// ----------------------------------------------------------------------------
// omd_pdly: pixel delay line
// Circular buffer of margin*width pixels, read before write at one pointer.
// ----------------------------------------------------------------------------
module omd_pdly import omd_pkg::*; #(
	parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
	parameter int MAX_MARGIN = DEF_MAX_MARGIN,
	localparam int DEPTH = MAX_MARGIN * MAX_WIDTH,
	localparam int PAW   = $clog2(DEPTH),
	localparam int LNW   = $clog2(DEPTH + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             adv,
	input  logic             take,
	input  logic             restart,
	input  logic [LNW-1:0]   len,
	input  logic [PIX_W-1:0] pix,
	output logic [PIX_W-1:0] pix_s1
);
	logic [PIX_W-1:0] mem [DEPTH];
	logic [PIX_W-1:0] rd_q;
	logic [PIX_W-1:0] byp_q;
	logic             zero_q;
	logic [PAW-1:0]   ptr_q;
	logic [PAW-1:0]   addr;

	assign addr = restart ? '0 : ptr_q;

	// wrap at the line length; a zero-length line parks the pointer at zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q <= '0;
		end else if (adv && take) begin
			if ((LNW'(addr) + LNW'(1)) >= len) begin
				ptr_q <= '0;
			end else begin
				ptr_q <= addr + PAW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && take) begin
			rd_q      <= mem[addr];
			mem[addr] <= pix;
			byp_q     <= pix;
			zero_q    <= (len == '0);
		end
	end

	assign pix_s1 = zero_q ? byp_q : rd_q;
endmodule

/* hdl/obstacle_margin_dilation.sv */
// ----------------------------------------------------------------------------
// obstacle_margin_dilation: obstacle inflation over a raster occupancy map
// Square-window dilation of below-threshold pixels, streamed in raster order.
// ----------------------------------------------------------------------------
// Map pixels enter in raster order, one request per clock, and the block
// keeps that rate for as long as the output side takes results: ready only
// drops once a result sits in the output register and a second one in the
// skid stage behind it. The result for pixel p follows the request
// p + margin*width + margin through stage 1, the cell chain and the output
// register; after the last map pixel send exactly margin*width + margin
// drain requests to flush the frame; the last result carries frame_last.
// Geometry, margin and threshold are sampled when a frame's first pixel is
// accepted. Inside, a column store of rows-since-obstacle counters (one
// read-modify-write a clock, one entry per column) gives the vertical
// extent of the window, a chain of 2*MAX_MARGIN+1 cells slides along the
// row for the horizontal extent, and a margin*width pixel delay line
// carries the original values. No clearing pass is needed after reset: the
// first row of each frame ignores whatever the column store holds. Drain
// requests sent while map pixels are still expected are taken and dropped.
module obstacle_margin_dilation import omd_pkg::*; #(
	parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
	parameter int MAX_MARGIN = DEF_MAX_MARGIN
) (
	input  logic              clk,
	input  logic              arst_n,
	omd_in_if.sink            map_in,
	omd_out_if.source         map_out,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready
);
	localparam int CAW   = $clog2(MAX_WIDTH);
	localparam int WW    = $clog2(MAX_WIDTH + 1);
	localparam int HW    = $clog2(MAX_HEIGHT + 1);
	localparam int RAW   = $clog2(MAX_HEIGHT);
	localparam int IRW   = $clog2(MAX_HEIGHT + 2 * MAX_MARGIN + 1);
	localparam int MGW   = $clog2(MAX_MARGIN + 1);
	localparam int VW    = $clog2(2 * MAX_MARGIN + 2);
	localparam int MWW   = $clog2(MAX_MARGIN * MAX_WIDTH + 1);
	localparam int DW    = $clog2(MAX_MARGIN * MAX_WIDTH + MAX_MARGIN + 1);
	localparam int NCELL = 2 * MAX_MARGIN + 1;
	localparam int SLW   = $clog2(NCELL);
	localparam int CMW   = $clog2(MAX_WIDTH + MAX_MARGIN);

	// configuration registers
	logic [CFG_DIM_W-1:0] cfg_width_q;
	logic [CFG_DIM_W-1:0] cfg_height_q;
	logic [CFG_MRG_W-1:0] cfg_margin_q;
	logic [PIX_W-1:0]     cfg_thr_q;
	logic                 cfg_wr;

	// frame state, sampled geometry and raster counters
	logic             open_q;
	logic [WW-1:0]    w_q;
	logic [HW-1:0]    h_q;
	logic [MGW-1:0]   m_q;
	logic [PIX_W-1:0] thr_q;
	logic [MWW-1:0]   mw_q;
	logic [DW-1:0]    rem_q;
	logic [CAW-1:0]   in_col_q;
	logic [IRW-1:0]   in_row_q;
	logic [CAW-1:0]   out_col_q;
	logic [RAW-1:0]   out_row_q;

	// clamped register values for a frame that starts now
	logic [WW-1:0]  w0;
	logic [HW-1:0]  h0;
	logic [MGW-1:0] m0;
	logic [MWW-1:0] mw0;
	logic [DW-1:0]  delay0;

	// effective frame context of the request at the input
	logic [WW-1:0]    f_w;
	logic [HW-1:0]    f_h;
	logic [MGW-1:0]   f_m;
	logic [PIX_W-1:0] f_thr;
	logic [MWW-1:0]   f_mw;
	logic [DW-1:0]    f_rem;
	logic [CAW-1:0]   f_incol;
	logic [IRW-1:0]   f_inrow;
	logic [CAW-1:0]   f_outcol;
	logic [RAW-1:0]   f_outrow;

	logic adv;
	logic acc;
	logic start;
	logic in_frame;
	logic eff;
	logic emit0;
	logic last0;
	logic obst0;
	logic in_col_end;
	logic out_col_end;

	// pipeline
	logic             valid_s1;
	logic             vf_s1;
	logic [PIX_W-1:0] pix_s1;
	logic             emit_s1;
	logic             last_s1;
	logic [CAW-1:0]   c_s1;
	logic [MGW-1:0]   m_s1;
	logic [WW-1:0]    w_s1;
	logic             emit_s2;
	logic             last_s2;
	logic [CAW-1:0]   c_s2;
	logic [MGW-1:0]   m_s2;
	logic [WW-1:0]    w_s2;

	logic             cell_vf  [NCELL];
	logic [PIX_W-1:0] cell_pix [NCELL];
	logic [NCELL-1:0] cell_hit;
	logic [CMW-1:0]   cm_s2;
	logic [VW-1:0]    span_s2;
	logic [PIX_W-1:0] res_pix;
	logic             push;
	logic             pop;

	// output register and skid stage
	logic             out_valid_q;
	logic [PIX_W-1:0] out_pix_q;
	logic             out_last_q;
	logic             skid_valid_q;
	logic [PIX_W-1:0] skid_pix_q;
	logic             skid_last_q;

	// ---------------------------------------------------------------- config
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_width_q  <= RST_FRAME_WIDTH;
			cfg_height_q <= RST_FRAME_HEIGHT;
			cfg_margin_q <= RST_MARGIN;
			cfg_thr_q    <= RST_THRESHOLD;
		end else if (cfg_wr) begin
			unique case (reg_idx_t'(paddr[3:2]))
				REG_FRAME_WIDTH:  cfg_width_q  <= pwdata[CFG_DIM_W-1:0];
				REG_FRAME_HEIGHT: cfg_height_q <= pwdata[CFG_DIM_W-1:0];
				REG_MARGIN:       cfg_margin_q <= pwdata[CFG_MRG_W-1:0];
				REG_THRESHOLD:    cfg_thr_q    <= pwdata[PIX_W-1:0];
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx_t'(paddr[3:2]))
			REG_FRAME_WIDTH:  prdata = APB_DW'(cfg_width_q);
			REG_FRAME_HEIGHT: prdata = APB_DW'(cfg_height_q);
			REG_MARGIN:       prdata = APB_DW'(cfg_margin_q);
			REG_THRESHOLD:    prdata = APB_DW'(cfg_thr_q);
		endcase
	end

	// clamp geometry: zero acts as one, oversize saturates to the limit
	always_comb begin
		if (cfg_width_q == '0) begin
			w0 = WW'(1);
		end else if (32'(cfg_width_q) > 32'(MAX_WIDTH)) begin
			w0 = WW'(MAX_WIDTH);
		end else begin
			w0 = WW'(cfg_width_q);
		end
		if (cfg_height_q == '0) begin
			h0 = HW'(1);
		end else if (32'(cfg_height_q) > 32'(MAX_HEIGHT)) begin
			h0 = HW'(MAX_HEIGHT);
		end else begin
			h0 = HW'(cfg_height_q);
		end
		if (32'(cfg_margin_q) > 32'(MAX_MARGIN)) begin
			m0 = MGW'(MAX_MARGIN);
		end else begin
			m0 = MGW'(cfg_margin_q);
		end
	end

	assign mw0    = MWW'(MWW'(m0) * MWW'(w0));
	assign delay0 = DW'(mw0) + DW'(m0);

	// ------------------------------------------------------------ input stage
	assign adv          = !skid_valid_q;
	assign map_in.ready = adv;
	assign acc          = map_in.valid && map_in.ready;
	assign start        = !open_q && (map_in.mode == MODE_PIXEL);

	// the first pixel of a frame runs on fresh geometry and zeroed raster counters
	assign f_w      = start ? w0 : w_q;
	assign f_h      = start ? h0 : h_q;
	assign f_m      = start ? m0 : m_q;
	assign f_thr    = start ? cfg_thr_q : thr_q;
	assign f_mw     = start ? mw0 : mw_q;
	assign f_rem    = start ? delay0 : rem_q;
	assign f_incol  = start ? '0 : in_col_q;
	assign f_inrow  = start ? '0 : in_row_q;
	assign f_outcol = start ? '0 : out_col_q;
	assign f_outrow = start ? '0 : out_row_q;

	// drop drain requests while map pixels are still due; past the frame a
	// pixel counts as a drain request
	assign in_frame    = f_inrow < IRW'(f_h);
	assign eff         = acc && (open_q || start)
		&& !(in_frame && (map_in.mode == MODE_DRAIN));
	assign emit0       = (f_rem == '0);
	assign in_col_end  = (WW'(f_incol) + WW'(1)) == f_w;
	assign out_col_end = (WW'(f_outcol) + WW'(1)) == f_w;
	assign last0       = emit0 && out_col_end && (HW'(f_outrow) + HW'(1) == f_h);
	assign obst0       = in_frame && (map_in.pixel_in < f_thr);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q    <= 1'b0;
			w_q       <= WW'(1);
			h_q       <= HW'(1);
			m_q       <= '0;
			thr_q     <= '0;
			mw_q      <= '0;
			rem_q     <= '0;
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
		end else if (eff) begin
			open_q <= !last0;
			w_q    <= f_w;
			h_q    <= f_h;
			m_q    <= f_m;
			thr_q  <= f_thr;
			mw_q   <= f_mw;
			rem_q  <= emit0 ? f_rem : f_rem - DW'(1);
			if (in_col_end) begin
				in_col_q <= '0;
				in_row_q <= f_inrow + IRW'(1);
			end else begin
				in_col_q <= f_incol + CAW'(1);
				in_row_q <= f_inrow;
			end
			if (emit0 && out_col_end) begin
				out_col_q <= '0;
				out_row_q <= f_outrow + RAW'(1);
			end else if (emit0) begin
				out_col_q <= f_outcol + CAW'(1);
				out_row_q <= f_outrow;
			end else begin
				out_col_q <= f_outcol;
				out_row_q <= f_outrow;
			end
		end
	end

	// ------------------------------------------- stage 1: column and delay
	omd_vert #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_MARGIN (MAX_MARGIN)
	) u_vert (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.take      (eff),
		.col       (f_incol),
		.first_row (f_inrow == '0),
		.obst      (obst0),
		.span      (VW'(2 * f_m)),
		.valid_s1  (valid_s1),
		.vf_s1     (vf_s1)
	);

	omd_pdly #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_MARGIN (MAX_MARGIN)
	) u_pdly (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.take    (eff),
		.restart (start),
		.len     (f_mw),
		.pix     (map_in.pixel_in),
		.pix_s1  (pix_s1)
	);

	// carry the frame context with each request so a new frame can follow
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			emit_s1 <= 1'b0;
			emit_s2 <= 1'b0;
		end else if (adv) begin
			emit_s1 <= eff && emit0;
			emit_s2 <= emit_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			last_s1 <= last0;
			c_s1    <= f_outcol;
			m_s1    <= f_m;
			w_s1    <= f_w;
			last_s2 <= last_s1;
			c_s2    <= c_s1;
			m_s2    <= m_s1;
			w_s2    <= w_s1;
		end
	end

	// --------------------------------------------- stage 2: window cell chain
	assign cm_s2   = CMW'(c_s2) + CMW'(m_s2);
	assign span_s2 = VW'(2 * m_s2);

	for (genvar k = 0; k < NCELL; k++) begin : g_cell
		logic             vf_feed;
		logic [PIX_W-1:0] pix_feed;

		if (k == 0) begin : g_head
			assign vf_feed  = vf_s1;
			assign pix_feed = pix_s1;
		end else begin : g_link
			assign vf_feed  = cell_vf[k-1];
			assign pix_feed = cell_pix[k-1];
		end

		omd_cell #(
			.MAX_WIDTH  (MAX_WIDTH),
			.MAX_MARGIN (MAX_MARGIN)
		) u_cell (
			.clk     (clk),
			.shift   (adv && valid_s1),
			.vf_in   (vf_feed),
			.pix_in  (pix_feed),
			.slot    (SLW'(k)),
			.cm      (cm_s2),
			.width   (w_s2),
			.span    (span_s2),
			.vf_out  (cell_vf[k]),
			.pix_out (cell_pix[k]),
			.hit     (cell_hit[k])
		);
	end

	// the centre of the window sits margin cells behind the newest one
	assign res_pix = (|cell_hit) ? '0 : cell_pix[SLW'(m_s2)];

	// ------------------------------------------------ output register + skid
	assign push = adv && emit_s2;
	assign pop  = out_valid_q && map_out.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (pop) begin
				skid_valid_q <= 1'b0;
			end
		end else if (push) begin
			if (out_valid_q && !pop) begin
				skid_valid_q <= 1'b1;
			end else begin
				out_valid_q <= 1'b1;
			end
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (pop) begin
				out_pix_q  <= skid_pix_q;
				out_last_q <= skid_last_q;
			end
		end else if (push) begin
			if (out_valid_q && !pop) begin
				skid_pix_q  <= res_pix;
				skid_last_q <= last_s2;
			end else begin
				out_pix_q  <= res_pix;
				out_last_q <= last_s2;
			end
		end
	end

	assign map_out.valid      = out_valid_q;
	assign map_out.pixel_out  = out_pix_q;
	assign map_out.frame_last = out_last_q;

	// ------------------------------------------------------------- assertions
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid stage holds a result while the output register is empty");

	a_close_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		(eff && last0) |=> !open_q)
		else $error("frame still open after its last result");

	a_col_in_row: assert property (@(posedge clk) disable iff (!arst_n)
		open_q |-> (WW'(in_col_q) < w_q))
		else $error("input column beyond frame width");

	a_skid_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(push && out_valid_q && !map_out.ready) |=> skid_valid_q)
		else $error("result lost while output register stalled");
endmodule
